@@ rtl/core/sorted_calibration_table_interpolator_core_defines.svh @@
// Assertion macros shared by the checker files of the calibration table core.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SORTED_CALIBRATION_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define SORTED_CALIBRATION_TABLE_INTERPOLATOR_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define SCTI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define SCTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/scti_pkg.sv @@
// Package for the calibration table core: sizes, codes, state and interface types.
// Depends on nothing; imported by scti_div, the core top level and scti_checker.
package scti_pkg;

    localparam int MAX_POINTS = 16;
    localparam int NUM_SLOTS  = 4;

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W  = $clog2(NUM_SLOTS * MAX_POINTS);
    localparam int DEPTH   = NUM_SLOTS * MAX_POINTS;

    localparam int RATIO_W = 16;
    localparam int VOL_W   = 20;
    localparam int DIFF_W  = VOL_W + 1;
    localparam int PROD_W  = RATIO_W + DIFF_W;

    localparam logic [RATIO_W-1:0] TOL_RESET = 16'd164;

    typedef enum logic [1:0] {
        CMD_CAPTURE = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_FORCE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UPDATED    = 3'd1,
        ST_FULL       = 3'd2,
        ST_NEG_VOLUME = 3'd3,
        ST_BAD_SLOT   = 3'd4,
        ST_UNDER_TWO  = 3'd5,
        ST_NO_POINTS  = 3'd6,
        ST_ZERO_WIDTH = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CAP_RD,
        S_CAP_CHK,
        S_CAP_DECIDE,
        S_SH_CHK,
        S_SH_WR,
        S_Q_RD,
        S_Q_CHK,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [RATIO_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [PROD_W-1:0]   quotient;
    } div_rsp_t;

    // Flat store address of one point in one slot's table.
    function automatic logic [ADDR_W-1:0] point_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [IDX_W-1:0] idx);
        point_addr = ADDR_W'(slot * MAX_POINTS + idx);
    endfunction

endpackage

@@ rtl/core/scti_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module scti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/scti_div.sv @@
// Serial restoring divider, one quotient bit per cycle, for unsigned operands.
// Depends on scti_pkg for widths and the request and response structs.
module scti_div (
    input  logic              clk,
    input  logic              rst_n,
    input  scti_pkg::div_req_t req,
    output scti_pkg::div_rsp_t rsp
);
    import scti_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0]  quo_reg, quo_next;
    logic [RATIO_W-1:0] rem_reg, rem_next;
    logic [RATIO_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [RATIO_W:0]   rem_shift;
    logic [RATIO_W:0]   rem_sub;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[PROD_W-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            step_next = STEP_W'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[RATIO_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[RATIO_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state resets; the datapath does not need to.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/core/sorted_calibration_table_interpolator_core.sv @@
// Channel   | Direction | Signals                              | Contents
// command   | in        | s_tvalid s_tready s_tdata s_tuser    | cmd, slot, ratio, volume
// result    | out       | m_tvalid m_tready m_tdata m_tuser    | status, volume_out, point_count
// config    | in        | cfg_we cfg_data                      | ratio_tolerance
//
// One command transaction is taken at a time; s_tready is high only while the sequencer idles.
// Clear, force-zero and rejected commands go from dispatch to the result. A capture walks the
// table with a read and a check state per point (one RAM read port) and shifts each moved point
// by a check and a write state. A query walks alike, then multiplies and runs 37 divide steps.
// Reset (rst_n, asynchronous) empties every table at once; no clearing pass is needed.
// A stalled result is held in the output register while the next command is accepted.
// Depends on scti_pkg, scti_ram and scti_div.
module sorted_calibration_table_interpolator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] slot, [18:3] ratio, [38:19] volume, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [19:0] volume_out, [24:20] point_count, [31:25] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_we,
    input  logic [15:0] cfg_data   // ratio_tolerance
);
    import scti_pkg::*;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [2:0]          slot_reg, slot_next;
    logic [RATIO_W-1:0]  ratio_reg, ratio_next;
    logic signed [VOL_W-1:0] vol_reg, vol_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    at_reg, at_next;
    logic                at_found_reg, at_found_next;
    logic [RATIO_W-1:0]  prev_r_reg, prev_r_next;
    logic signed [VOL_W-1:0] prev_v_reg, prev_v_next;
    logic [RATIO_W-1:0]  mul_a_reg, mul_a_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [RATIO_W-1:0]  den_reg, den_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                neg_reg, neg_next;
    status_t             res_status_reg, res_status_next;
    logic signed [VOL_W-1:0] res_vol_reg, res_vol_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic signed [VOL_W-1:0] out_vol_reg, out_vol_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic [RATIO_W-1:0]  tol_reg;
    logic [CNT_W-1:0]    counts_reg [NUM_SLOTS];
    logic                cnt_we;
    logic [CNT_W-1:0]    cnt_wdata;

    logic                r_we, v_we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [RATIO_W-1:0]  r_wdata, r_rdata;
    logic [VOL_W-1:0]    v_wdata, v_rdata;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [SLOT_W-1:0]   slot_idx;
    logic                slot_ok;
    logic [RATIO_W-1:0]  ratio_dist;
    logic [DIFF_W-1:0]   q_signed;
    logic [DIFF_W-1:0]   sum;

    assign slot_idx = slot_reg[SLOT_W-1:0];
    assign slot_ok  = (32'(slot_reg) < NUM_SLOTS);

    // Point stores: ratio and volume each in a RAM of their own.
    scti_ram #(.WIDTH(RATIO_W), .DEPTH(DEPTH)) u_ratio_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (waddr),
        .wdata (r_wdata),
        .raddr (raddr),
        .rdata (r_rdata)
    );

    scti_ram #(.WIDTH(VOL_W), .DEPTH(DEPTH)) u_volume_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (waddr),
        .wdata (v_wdata),
        .raddr (raddr),
        .rdata (v_rdata)
    );

    // Serial divider for the interpolation quotient.
    scti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign ratio_dist = (r_rdata > ratio_reg) ? (r_rdata - ratio_reg)
                                              : (ratio_reg - r_rdata);
    assign q_signed = neg_reg ? (DIFF_W'(0) - div_rsp.quotient[DIFF_W-1:0])
                              : div_rsp.quotient[DIFF_W-1:0];
    assign sum      = {prev_v_reg[VOL_W-1], prev_v_reg} + q_signed;

    // Sequencer: next state, memory control and result values.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        slot_next       = slot_reg;
        ratio_next      = ratio_reg;
        vol_next        = vol_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        at_next         = at_reg;
        at_found_next   = at_found_reg;
        prev_r_next     = prev_r_reg;
        prev_v_next     = prev_v_reg;
        mul_a_next      = mul_a_reg;
        diff_next       = diff_reg;
        den_next        = den_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        res_status_next = res_status_reg;
        res_vol_next    = res_vol_reg;
        res_cnt_next    = res_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_vol_next    = out_vol_reg;
        out_cnt_next    = out_cnt_reg;
        cnt_we          = 1'b0;
        cnt_wdata       = '0;
        r_we            = 1'b0;
        v_we            = 1'b0;
        waddr           = point_addr(slot_idx, idx_reg[IDX_W-1:0]);
        raddr           = point_addr(slot_idx, idx_reg[IDX_W-1:0]);
        r_wdata         = ratio_reg;
        v_wdata         = vol_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg[PROD_W-1] ? (PROD_W'(0) - prod_reg) : prod_reg;
        div_req.divisor  = den_reg;
        s_tready        = (state_reg == S_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tuser);
                    slot_next  = s_tdata[2:0];
                    ratio_next = s_tdata[18:3];
                    vol_next   = s_tdata[38:19];
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                n_next = slot_ok ? counts_reg[slot_idx] : '0;
                state_next = S_DONE;
                res_vol_next = '0;
                res_cnt_next = n_next;
                idx_next = '0;
                if (!slot_ok)
                begin
                    res_status_next = ST_BAD_SLOT;
                end
                else
                begin
                    unique case (cmd_reg)
                        CMD_CAPTURE:
                        begin
                            at_next       = n_next;
                            at_found_next = 1'b0;
                            if (vol_reg < 0)
                            begin
                                res_status_next = ST_NEG_VOLUME;
                            end
                            else if (n_next == '0)
                            begin
                                state_next = S_CAP_DECIDE;
                            end
                            else
                            begin
                                state_next = S_CAP_RD;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (n_next < CNT_W'(2))
                            begin
                                res_status_next = ST_UNDER_TWO;
                            end
                            else
                            begin
                                state_next = S_Q_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt_we          = 1'b1;
                            cnt_wdata       = '0;
                            res_status_next = ST_OK;
                            res_cnt_next    = '0;
                        end
                        CMD_FORCE:
                        begin
                            if (n_next == '0)
                            begin
                                res_status_next = ST_NO_POINTS;
                            end
                            else
                            begin
                                // The first point of the table is at index zero.
                                waddr           = point_addr(slot_idx, IDX_W'(0));
                                v_we            = 1'b1;
                                v_wdata         = '0;
                                res_status_next = ST_OK;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Capture: look for a point within tolerance and the insert position.
            S_CAP_RD:
            begin
                state_next = S_CAP_CHK;
            end

            S_CAP_CHK:
            begin
                if (ratio_dist <= tol_reg)
                begin
                    v_we            = 1'b1;
                    res_status_next = ST_UPDATED;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (!at_found_reg && (r_rdata >= ratio_reg))
                    begin
                        at_next       = idx_reg;
                        at_found_next = 1'b1;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                    state_next = (idx_next == n_reg) ? S_CAP_DECIDE : S_CAP_RD;
                end
            end

            S_CAP_DECIDE:
            begin
                if (32'(n_reg) >= MAX_POINTS)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = n_reg;
                    state_next = S_SH_CHK;
                end
            end

            // Shift points at and above the insert position up by one, then insert.
            S_SH_CHK:
            begin
                raddr = point_addr(slot_idx, IDX_W'(idx_reg - CNT_W'(1)));
                if (idx_reg == at_reg)
                begin
                    r_we            = 1'b1;
                    v_we            = 1'b1;
                    cnt_we          = 1'b1;
                    cnt_wdata       = n_reg + CNT_W'(1);
                    res_status_next = ST_OK;
                    res_cnt_next    = cnt_wdata;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                r_we       = 1'b1;
                v_we       = 1'b1;
                r_wdata    = r_rdata;
                v_wdata    = v_rdata;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = S_SH_CHK;
            end

            // Query: walk to the segment that holds the ratio.
            S_Q_RD:
            begin
                state_next = S_Q_CHK;
            end

            S_Q_CHK:
            begin
                if (idx_reg == '0)
                begin
                    if (ratio_reg <= r_rdata)
                    begin
                        res_status_next = ST_OK;
                        res_vol_next    = v_rdata;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        prev_r_next = r_rdata;
                        prev_v_next = v_rdata;
                        idx_next    = CNT_W'(1);
                        state_next  = S_Q_RD;
                    end
                end
                else if ((idx_reg == n_reg - CNT_W'(1)) && (ratio_reg >= r_rdata))
                begin
                    res_status_next = ST_OK;
                    res_vol_next    = v_rdata;
                    state_next      = S_DONE;
                end
                else if (ratio_reg <= r_rdata)
                begin
                    if (r_rdata <= prev_r_reg)
                    begin
                        res_status_next = ST_ZERO_WIDTH;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        mul_a_next = ratio_reg - prev_r_reg;
                        den_next   = r_rdata - prev_r_reg;
                        diff_next  = {v_rdata[VOL_W-1], v_rdata}
                                   - {prev_v_reg[VOL_W-1], prev_v_reg};
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    prev_r_next = r_rdata;
                    prev_v_next = v_rdata;
                    idx_next    = idx_reg + CNT_W'(1);
                    state_next  = S_Q_RD;
                end
            end

            S_MUL:
            begin
                prod_next  = $signed({1'b0, mul_a_reg}) * diff_reg;
                state_next = S_DIV_START;
            end

            S_DIV_START:
            begin
                div_req.start = 1'b1;
                neg_next      = prod_reg[PROD_W-1];
                state_next    = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_status_next = ST_OK;
                    res_vol_next    = sum[VOL_W-1:0];
                    state_next      = S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_vol_next    = res_vol_reg;
                    out_cnt_next    = res_cnt_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers, point counts and the tolerance register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
            if (cnt_we)
            begin
                counts_reg[slot_idx] <= cnt_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        slot_reg       <= slot_next;
        ratio_reg      <= ratio_next;
        vol_reg        <= vol_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        at_reg         <= at_next;
        at_found_reg   <= at_found_next;
        prev_r_reg     <= prev_r_next;
        prev_v_reg     <= prev_v_next;
        mul_a_reg      <= mul_a_next;
        diff_reg       <= diff_next;
        den_reg        <= den_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        res_status_reg <= res_status_next;
        res_vol_reg    <= res_vol_next;
        res_cnt_reg    <= res_cnt_next;
        out_status_reg <= out_status_next;
        out_vol_reg    <= out_vol_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_cnt_reg, out_vol_reg};

endmodule

@@ rtl/core/scti_checker.sv @@
// Port-level checker for the calibration table core, bound to the top level.
// Depends on scti_pkg and the assertion macros header.
`include "sorted_calibration_table_interpolator_core_defines.svh"

module scti_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        cfg_we,
    input logic [15:0] cfg_data
);
    import scti_pkg::*;

    // A result held back by the consumer stays valid and unchanged.
    `SCTI_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `SCTI_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready,
                      $stable(m_tdata) && $stable(m_tuser))
    // Commands are worked one at a time: no accept right after an accept.
    `SCTI_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // Every status other than success carries a zero volume.
    `SCTI_ASSERT_SAME(a_err_zero_vol, clk, rst_n, m_tvalid && (m_tuser != ST_OK),
                      m_tdata[19:0] == 20'd0)

endmodule

bind sorted_calibration_table_interpolator_core scti_checker u_scti_checker (.*);
